@@ src/assert_macros.svh @@
// Assertion macros shared by the checker files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/bbp_pkg.sv @@
// Types and constants for the two-ball bounce pixel generator.
// No dependencies.
package bbp_pkg;

  localparam int unsigned SCREEN_W = 800;
  localparam int unsigned SCREEN_H = 480;

  localparam logic [23:0] COLOR_RED   = 24'hFF0000;
  localparam logic [23:0] COLOR_WHITE = 24'hFFFFFF;
  localparam logic [23:0] COLOR_BLACK = 24'h000000;

  localparam logic [11:0] SMALL_CX_RST = 12'd400;
  localparam logic [11:0] SMALL_CY_RST = 12'd240;
  localparam logic [11:0] LARGE_CX_RST = 12'd240;
  localparam logic [11:0] LARGE_CY_RST = 12'd60;

  localparam logic [6:0] SMALL_RADIUS_RST = 7'd30;
  localparam logic [6:0] LARGE_RADIUS_RST = 7'd50;
  localparam logic [3:0] SMALL_STEP_RST   = 4'd2;
  localparam logic [3:0] LARGE_STEP_RST   = 4'd3;

  typedef enum logic {
    FUNC_PIXEL = 1'b0,
    FUNC_TICK  = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    REG_SMALL_RADIUS = 3'd0,
    REG_LARGE_RADIUS = 3'd1,
    REG_SMALL_STEP   = 3'd2,
    REG_LARGE_STEP   = 3'd3
  } cfg_reg_e;

  // direction bits: 0 small x, 1 small y, 2 large x, 3 large y; set = negative
  localparam int unsigned DIR_SX = 0;
  localparam int unsigned DIR_SY = 1;
  localparam int unsigned DIR_LX = 2;
  localparam int unsigned DIR_LY = 3;

  typedef struct packed {
    logic       func;
    logic [9:0] pix_x;
    logic [8:0] pix_y;
  } in_item_t;

  typedef struct packed {
    logic [23:0] color;
    logic        collided;
  } out_item_t;

  typedef struct packed {
    logic [6:0] small_radius;
    logic [6:0] large_radius;
    logic [3:0] small_step;
    logic [3:0] large_step;
  } cfg_t;

  typedef struct packed {
    logic [11:0] small_cx;
    logic [11:0] small_cy;
    logic [11:0] large_cx;
    logic [11:0] large_cy;
    logic [3:0]  dir;
    logic        swap;
  } ball_state_t;

  function automatic logic [11:0] move12(input logic [11:0] c, input logic [3:0] step,
                                         input logic neg);
    logic [11:0] s;
    s = {8'd0, step};
    return neg ? (c - s) : (c + s);
  endfunction

  // center in the edge band: c <= r or c >= size - r, c taken as signed
  function automatic logic in_band(input logic [11:0] c, input logic [6:0] r,
                                   input logic [11:0] size);
    logic signed [12:0] v;
    logic signed [12:0] lo;
    logic signed [12:0] hi;
    v  = signed'({c[11], c});
    lo = signed'({6'd0, r});
    hi = signed'({1'b0, size}) - lo;
    return (v <= lo) || (v >= hi);
  endfunction

  function automatic logic signed [12:0] sext_c(input logic [11:0] c);
    return signed'({c[11], c});
  endfunction

endpackage

@@ src/bbp_in_circle.sv @@
// Distance test: (a - b) squared summed over both axes against r squared.
// Depends on nothing outside this file.
module bbp_in_circle (
  input  logic signed [12:0] ax,
  input  logic signed [12:0] ay,
  input  logic signed [12:0] bx,
  input  logic signed [12:0] by,
  input  logic        [7:0]  r,
  output logic               covered
);

  logic signed [13:0] dx;
  logic signed [13:0] dy;
  logic signed [27:0] sqx;
  logic signed [27:0] sqy;
  logic        [28:0] sum;
  logic        [15:0] rr;

  assign dx  = 14'(ax) - 14'(bx);
  assign dy  = 14'(ay) - 14'(by);
  assign sqx = dx * dx;
  assign sqy = dy * dy;
  assign sum = 29'($unsigned(sqx)) + 29'($unsigned(sqy));
  assign rr  = 16'(r) * 16'(r);
  assign covered = sum <= 29'(rr);

endmodule

@@ src/bbp_pixel.sv @@
// Pixel color: small ball, then large ball over it, on white.
// Depends on bbp_pkg and bbp_in_circle.
module bbp_pixel (
  input  logic [9:0]           pix_x,
  input  logic [8:0]           pix_y,
  input  bbp_pkg::ball_state_t st,
  input  bbp_pkg::cfg_t        cfg,
  output logic [23:0]          color
);

  logic signed [12:0] px;
  logic signed [12:0] py;
  logic               in_small;
  logic               in_large;

  assign px = signed'({3'd0, pix_x});
  assign py = signed'({4'd0, pix_y});

  bbp_in_circle u_small (
    .ax      (px),
    .ay      (py),
    .bx      (bbp_pkg::sext_c(st.small_cx)),
    .by      (bbp_pkg::sext_c(st.small_cy)),
    .r       ({1'b0, cfg.small_radius}),
    .covered (in_small)
  );

  bbp_in_circle u_large (
    .ax      (px),
    .ay      (py),
    .bx      (bbp_pkg::sext_c(st.large_cx)),
    .by      (bbp_pkg::sext_c(st.large_cy)),
    .r       ({1'b0, cfg.large_radius}),
    .covered (in_large)
  );

  always_comb begin
    color = bbp_pkg::COLOR_WHITE;
    if (in_small) begin
      color = st.swap ? bbp_pkg::COLOR_BLACK : bbp_pkg::COLOR_RED;
    end
    if (in_large) begin
      color = st.swap ? bbp_pkg::COLOR_RED : bbp_pkg::COLOR_BLACK;
    end
  end

endmodule

@@ src/bbp_motion.sv @@
// Frame tick: move centers, bounce at edge bands, flip all on collision.
// Depends on bbp_pkg and bbp_in_circle.
module bbp_motion (
  input  bbp_pkg::ball_state_t st,
  input  bbp_pkg::cfg_t        cfg,
  output bbp_pkg::ball_state_t st_next,
  output logic                 hit
);

  logic [11:0] scx;
  logic [11:0] scy;
  logic [11:0] lcx;
  logic [11:0] lcy;
  logic [3:0]  band;

  assign scx = bbp_pkg::move12(st.small_cx, cfg.small_step, st.dir[bbp_pkg::DIR_SX]);
  assign scy = bbp_pkg::move12(st.small_cy, cfg.small_step, st.dir[bbp_pkg::DIR_SY]);
  assign lcx = bbp_pkg::move12(st.large_cx, cfg.large_step, st.dir[bbp_pkg::DIR_LX]);
  assign lcy = bbp_pkg::move12(st.large_cy, cfg.large_step, st.dir[bbp_pkg::DIR_LY]);

  assign band[bbp_pkg::DIR_SX] =
    bbp_pkg::in_band(scx, cfg.small_radius, 12'(bbp_pkg::SCREEN_W));
  assign band[bbp_pkg::DIR_SY] =
    bbp_pkg::in_band(scy, cfg.small_radius, 12'(bbp_pkg::SCREEN_H));
  assign band[bbp_pkg::DIR_LX] =
    bbp_pkg::in_band(lcx, cfg.large_radius, 12'(bbp_pkg::SCREEN_W));
  assign band[bbp_pkg::DIR_LY] =
    bbp_pkg::in_band(lcy, cfg.large_radius, 12'(bbp_pkg::SCREEN_H));

  bbp_in_circle u_hit (
    .ax      (bbp_pkg::sext_c(scx)),
    .ay      (bbp_pkg::sext_c(scy)),
    .bx      (bbp_pkg::sext_c(lcx)),
    .by      (bbp_pkg::sext_c(lcy)),
    .r       (8'(cfg.small_radius) + 8'(cfg.large_radius)),
    .covered (hit)
  );

  always_comb begin
    st_next.small_cx = scx;
    st_next.small_cy = scy;
    st_next.large_cx = lcx;
    st_next.large_cy = lcy;
    st_next.dir      = st.dir ^ band ^ {4{hit}};
    st_next.swap     = st.swap ^ hit;
  end

endmodule

@@ src/two_ball_bounce_pixel_generator.sv @@
// Pipeline: an accepted item passes the input register, then the result register.
// Throughput: 1 item per cycle while the output is not stalled; a tick updates ball state
// as it enters the result register, so the next item already sees the moved balls.
// Reset: radii 30/50, steps 2/3, centers (400,240) and (240,60), all directions positive,
// no color swap, both pipeline stages empty.
module two_ball_bounce_pixel_generator (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bbp_pkg::in_item_t in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output bbp_pkg::out_item_t out_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [7:0]        cfg_data
);

  logic                 item_valid;
  bbp_pkg::in_item_t    item;
  bbp_pkg::cfg_t        cfg;
  bbp_pkg::ball_state_t st;
  bbp_pkg::ball_state_t st_tick;
  logic                 hit;
  logic [23:0]          pix_color;
  logic                 advance;
  logic                 is_tick;
  bbp_pkg::out_item_t   result;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || out_ready;
  assign in_ready  = !item_valid || advance;
  assign is_tick   = item.func == bbp_pkg::FUNC_TICK;

  bbp_pixel u_pixel (
    .pix_x (item.pix_x),
    .pix_y (item.pix_y),
    .st    (st),
    .cfg   (cfg),
    .color (pix_color)
  );

  bbp_motion u_motion (
    .st      (st),
    .cfg     (cfg),
    .st_next (st_tick),
    .hit     (hit)
  );

  always_comb begin
    if (is_tick) begin
      result.color    = 24'd0;
      result.collided = hit;
    end else begin
      result.color    = pix_color;
      result.collided = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid       <= 1'b0;
      out_valid        <= 1'b0;
      cfg.small_radius <= bbp_pkg::SMALL_RADIUS_RST;
      cfg.large_radius <= bbp_pkg::LARGE_RADIUS_RST;
      cfg.small_step   <= bbp_pkg::SMALL_STEP_RST;
      cfg.large_step   <= bbp_pkg::LARGE_STEP_RST;
      st.small_cx      <= bbp_pkg::SMALL_CX_RST;
      st.small_cy      <= bbp_pkg::SMALL_CY_RST;
      st.large_cx      <= bbp_pkg::LARGE_CX_RST;
      st.large_cy      <= bbp_pkg::LARGE_CY_RST;
      st.dir           <= 4'd0;
      st.swap          <= 1'b0;
    end else begin
      if (in_ready) begin
        item_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= item_valid;
      end
      if (advance && item_valid && is_tick) begin
        st <= st_tick;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (bbp_pkg::cfg_reg_e'(cfg_index))
          bbp_pkg::REG_SMALL_RADIUS: cfg.small_radius <= cfg_data[6:0];
          bbp_pkg::REG_LARGE_RADIUS: cfg.large_radius <= cfg_data[6:0];
          bbp_pkg::REG_SMALL_STEP:   cfg.small_step   <= cfg_data[3:0];
          bbp_pkg::REG_LARGE_STEP:   cfg.large_step   <= cfg_data[3:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
    if (advance && item_valid) begin
      out_item <= result;
    end
  end

endmodule

@@ src/bbp_checker.sv @@
// Port-level checks for the two-ball bounce pixel generator, bound to the top level.
// Depends on bbp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bbp_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input bbp_pkg::out_item_t out_item
);

  `ASSERT_CLK_RST(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_item), "result item changed while stalled")
  `ASSERT_CLK(a_rst_empty, clk, rst |=> !out_valid, "result valid right after reset")
  `ASSERT_CLK_RST(a_backpressure, clk, rst, !in_ready |-> out_valid && !out_ready, "input stalled without output stall")
  `ASSERT_CLK_RST(a_color_set, clk, rst, out_valid |-> out_item.color == bbp_pkg::COLOR_RED || out_item.color == bbp_pkg::COLOR_WHITE || out_item.color == bbp_pkg::COLOR_BLACK, "result color outside palette")

endmodule

bind two_ball_bounce_pixel_generator bbp_checker u_bbp_checker (.*);
